[rtl/bped_pkg.sv]
// Shared types and constants for the bi-phase IR edge decoder.
// Used by every module of the decoder; depends on nothing.
package bped_pkg;

	localparam int TIME_W     = 16;
	localparam int HALF_W     = 14;
	localparam int STORE_W    = 15;
	localparam int COUNT_W    = 5;
	localparam int CMD_W      = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [HALF_W-1:0]  HALF_BIT_RESET = HALF_W'(347);
	localparam logic [TIME_W-1:0]  TIMEOUT_RESET  = TIME_W'(10500);
	localparam logic [COUNT_W-1:0] MIN_FRAME_BITS = COUNT_W'(14);
	localparam logic [COUNT_W-1:0] COUNT_MAX      = COUNT_W'(16);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'b1;

	// gap length classes, in half-bit times
	typedef logic [1:0] gap_class_t;
	localparam gap_class_t GAP_SHORT = 2'd0;
	localparam gap_class_t GAP_TWO   = 2'd1;
	localparam gap_class_t GAP_THREE = 2'd2;
	localparam gap_class_t GAP_FOUR  = 2'd3;

	typedef struct packed {
		logic               watch_rising;
		logic               frame_done;
		logic [STORE_W-1:0] frame_bits;
	} result_t;

endpackage

[rtl/bped_gap_classifier.sv]
// Sorts one edge-to-edge gap into 2, 3 or 4+ half-bit times (or shorter).
// Depends on bped_pkg.
module bped_gap_classifier (
	input  logic [bped_pkg::TIME_W-1:0] gap,
	input  logic [bped_pkg::HALF_W-1:0] half_bit,
	output bped_pkg::gap_class_t        gap_class
);
	import bped_pkg::*;

	logic [TIME_W:0] h2;
	logic [TIME_W:0] h3;
	logic [TIME_W:0] h4;
	logic [TIME_W:0] gap_x;

	assign h2    = {2'b00, half_bit, 1'b0};
	assign h3    = h2 + {3'b000, half_bit};
	assign h4    = {1'b0, half_bit, 2'b00};
	assign gap_x = {1'b0, gap};

	// thresholds rise monotonically, so the first hit wins
	always_comb begin
		if (gap_x < h2) begin
			gap_class = GAP_SHORT;
		end else if (gap_x < h3) begin
			gap_class = GAP_TWO;
		end else if (gap_x < h4) begin
			gap_class = GAP_THREE;
		end else begin
			gap_class = GAP_FOUR;
		end
	end

endmodule

[rtl/bped_frame_state.sv]
// Frame state of the decoder: timing, bit store, count and latched frame.
// Updates once per stepped item; depends on bped_pkg and bped_gap_classifier.
module bped_frame_state (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  logic [bped_pkg::TIME_W-1:0]     edge_time,
	input  logic [bped_pkg::HALF_W-1:0]     half_bit,
	input  logic [bped_pkg::TIME_W-1:0]     timeout,
	output bped_pkg::result_t               result
);
	import bped_pkg::*;

	logic [TIME_W-1:0]  frame_start_q;
	logic [TIME_W-1:0]  prev_edge_q;
	logic [COUNT_W-1:0] bit_count_q;
	logic               awaiting_q;
	logic               first_gap_q;
	logic [STORE_W-1:0] store_q;
	logic [STORE_W-1:0] latched_q;
	logic               rising_q;

	logic [TIME_W-1:0]  since;
	logic               timed_out;
	logic [TIME_W-1:0]  gap;
	gap_class_t         gap_class;
	logic [COUNT_W-1:0] n1;
	logic [COUNT_W-1:0] n2;
	logic               prev_bit;
	logic [STORE_W-1:0] store_g;
	logic [COUNT_W-1:0] count_g;

	logic [TIME_W-1:0]  frame_start_d;
	logic [TIME_W-1:0]  prev_edge_d;
	logic [COUNT_W-1:0] bit_count_d;
	logic               awaiting_d;
	logic               first_gap_d;
	logic [STORE_W-1:0] store_d;
	logic [STORE_W-1:0] latched_d;
	logic               rising_d;
	logic               done_d;

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
		return (c < COUNT_MAX) ? c + COUNT_W'(1) : c;
	endfunction

	function automatic logic get_bit(input logic [STORE_W-1:0] s,
					 input logic [COUNT_W-1:0] i);
		return (i < COUNT_W'(STORE_W)) ? s[i[COUNT_W-2:0]] : 1'b0;
	endfunction

	// drop writes past the end of the store
	function automatic logic [STORE_W-1:0] set_bit(input logic [STORE_W-1:0] s,
						       input logic [COUNT_W-1:0] i,
						       input logic v);
		logic [STORE_W-1:0] r;
		r = s;
		if (i < COUNT_W'(STORE_W)) begin
			r[i[COUNT_W-2:0]] = v;
		end
		return r;
	endfunction

	assign since     = edge_time - frame_start_q;
	assign timed_out = since > timeout;
	// the first gap of a frame is measured from the start edge, half a bit late
	assign gap = edge_time - prev_edge_q +
		     ((first_gap_q && !timed_out) ? {2'b00, half_bit} : TIME_W'(0));

	bped_gap_classifier u_class (
		.gap       (gap),
		.half_bit  (half_bit),
		.gap_class (gap_class)
	);

	assign n1       = sat_inc(bit_count_q);
	assign n2       = sat_inc(n1);
	assign prev_bit = get_bit(store_q, n1 - COUNT_W'(1));

	always_comb begin
		store_g = store_q;
		count_g = n1;
		case (gap_class)
			GAP_TWO: begin
				store_g = set_bit(store_q, n1, prev_bit);
			end
			GAP_THREE: begin
				if (prev_bit) begin
					store_g = set_bit(set_bit(store_q, n1, 1'b1), n2, 1'b0);
					count_g = n2;
				end else begin
					store_g = set_bit(store_q, n1, 1'b1);
				end
			end
			GAP_FOUR: begin
				store_g = set_bit(set_bit(store_q, n1, 1'b1), n2, 1'b0);
				count_g = n2;
			end
			default: begin
				store_g = store_q;
			end
		endcase
	end

	always_comb begin
		frame_start_d = frame_start_q;
		prev_edge_d   = edge_time;
		bit_count_d   = count_g;
		awaiting_d    = awaiting_q;
		first_gap_d   = first_gap_q;
		store_d       = store_g;
		latched_d     = latched_q;
		rising_d      = rising_q;
		done_d        = 1'b0;
		if (awaiting_q) begin
			frame_start_d = edge_time;
			rising_d      = 1'b1;
			awaiting_d    = 1'b0;
			first_gap_d   = 1'b1;
			store_d       = {store_q[STORE_W-1:1], 1'b1};
			bit_count_d   = '0;
		end else if (timed_out) begin
			rising_d   = 1'b0;
			awaiting_d = 1'b1;
			// short frames keep store and count until the next start
			if (count_g >= MIN_FRAME_BITS) begin
				latched_d   = store_g;
				store_d     = '0;
				bit_count_d = '0;
				done_d      = 1'b1;
			end
		end else begin
			first_gap_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_start_q <= TIME_W'(1);
			prev_edge_q   <= TIME_W'(1);
			bit_count_q   <= COUNT_W'(1);
			awaiting_q    <= 1'b1;
			first_gap_q   <= 1'b1;
			store_q       <= '0;
			latched_q     <= '0;
			rising_q      <= 1'b0;
		end else if (step) begin
			frame_start_q <= frame_start_d;
			prev_edge_q   <= prev_edge_d;
			bit_count_q   <= bit_count_d;
			awaiting_q    <= awaiting_d;
			first_gap_q   <= first_gap_d;
			store_q       <= store_d;
			latched_q     <= latched_d;
			rising_q      <= rising_d;
		end
	end

	assign result.watch_rising = rising_d;
	assign result.frame_done   = done_d;
	assign result.frame_bits   = latched_d;

endmodule

[rtl/biphase_ir_edge_decoder_core.sv]
// Top level of the bi-phase IR edge decoder: channel registers and config.
// Depends on bped_pkg and bped_frame_state.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | edge_time
//  out     | out_valid / out_ready| watch_rising frame_done command toggle
//          |                      | frame_bits
//  cfg     | cfg_valid / cfg_ready| cfg_index cfg_data (always ready)
//
// An accepted item is held in the input register and is then decoded into the result
// register by the frame state update; one item per cycle is sustained while the output
// does not stall.
// Reset clears both pipeline valids and puts the frame state in its start state;
// no clearing pass is needed.
// A stalled result holds in place; the input register still takes an item while
// it is empty or draining, so the input stalls only when both stages are full.
module biphase_ir_edge_decoder_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [bped_pkg::TIME_W-1:0]       edge_time,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              watch_rising,
	output logic                              frame_done,
	output logic [bped_pkg::CMD_W-1:0]        command,
	output logic                              toggle,
	output logic [bped_pkg::STORE_W-1:0]      frame_bits,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bped_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bped_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import bped_pkg::*;

	logic [HALF_W-1:0] half_bit_q;
	logic [TIME_W-1:0] timeout_q;
	logic              valid_s1;
	logic [TIME_W-1:0] edge_time_s1;
	logic              valid_s2;
	result_t           res_s2;
	result_t           res_next;
	logic              advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_bit_q <= HALF_BIT_RESET;
			timeout_q  <= TIMEOUT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_HALF_BIT: half_bit_q <= cfg_data[HALF_W-1:0];
				CFG_TIMEOUT:  timeout_q  <= cfg_data[TIME_W-1:0];
				default:      half_bit_q <= half_bit_q;
			endcase
		end
	end

	// move the held item into the result register when it is empty or draining
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			edge_time_s1 <= edge_time;
		end
	end

	bped_frame_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.edge_time (edge_time_s1),
		.half_bit  (half_bit_q),
		.timeout   (timeout_q),
		.result    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid    = valid_s2;
	assign watch_rising = res_s2.watch_rising;
	assign frame_done   = res_s2.frame_done;
	assign frame_bits   = res_s2.frame_bits;
	assign toggle       = res_s2.frame_bits[3];
	// bit 9 of the frame is the command's most significant bit
	assign command = {res_s2.frame_bits[9], res_s2.frame_bits[10], res_s2.frame_bits[11],
			  res_s2.frame_bits[12], res_s2.frame_bits[13], res_s2.frame_bits[14]};

endmodule

[rtl/bped_checker.sv]
// Port-level checks for the bi-phase IR edge decoder, bound to the top level.
// Depends on bped_pkg.
module bped_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic                              watch_rising,
	input  logic                              frame_done,
	input  logic [bped_pkg::CMD_W-1:0]        command,
	input  logic                              toggle,
	input  logic [bped_pkg::STORE_W-1:0]      frame_bits
);
	import bped_pkg::*;

	// a frame closes on a timeout edge, which always rearms for falling
	a_done_watch_falling: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> !watch_rising)
		else $error("frame_done with watch_rising set");

	// every latched frame starts with its forced leading one
	a_done_lead_bit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> frame_bits[0])
		else $error("latched frame without bit 0 set");

	a_command_map: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (command[5] == frame_bits[9]) && (command[0] == frame_bits[14])
			      && (toggle == frame_bits[3]))
		else $error("command or toggle disagree with frame_bits");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_bits)
					   && $stable(frame_done))
		else $error("stalled result changed");

endmodule

bind biphase_ir_edge_decoder_core bped_checker u_bped_checker (.*);
